// ----- rtl/lcs_pkg.sv -----
// Package for the level-controlled command status block.
// Holds the state codes, the error codes, the register indexes and the field widths.
// No dependencies.
package lcs_pkg;

    // Field and register widths.
    localparam int TimerWidth   = 16;
    localparam int StateWidth   = 3;
    localparam int ErrCodeWidth = 2;
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 16;
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 16;

    // State codes as reported in state_code.
    localparam logic [StateWidth-1:0] ST_DORMANT   = 3'd0;
    localparam logic [StateWidth-1:0] ST_EXECUTING = 3'd1;
    localparam logic [StateWidth-1:0] ST_ABORTING  = 3'd2;
    localparam logic [StateWidth-1:0] ST_DONE      = 3'd3;
    localparam logic [StateWidth-1:0] ST_ERROR     = 3'd4;
    localparam logic [StateWidth-1:0] ST_RESETTING = 3'd5;

    // Error codes as reported in error_code.
    localparam logic [ErrCodeWidth-1:0] ERR_NONE     = 2'd0;
    localparam logic [ErrCodeWidth-1:0] ERR_EXTERNAL = 2'd1;
    localparam logic [ErrCodeWidth-1:0] ERR_TIMEOUT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_CYCLE_LIMIT     = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_TIMEOUT_TICKS   = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CONTINUOUS_MODE = 2'd2;

    // One input beat, unpacked from s_tdata.
    typedef struct packed {
        logic reset_finished;
        logic reset_request;
        logic abort_finished;
        logic ready_condition;
        logic fault_condition;
        logic enable;
        logic tick;
    } lcs_in_t;

endpackage

// ----- rtl/level_control_status_fsm_core.sv -----
// Top level of the level-controlled command status block: one scan step per beat.
// Depends on lcs_pkg (codes, widths and the input beat type).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata[7:0]: scan conditions
//  m_      | out       | m_tvalid/m_tready  | m_tdata[15:0]: status flags and state
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata: register writes
//
// A new beat is accepted every cycle while the result register is empty or being
// drained. The step is a single state decision plus two 16-bit timer decrements,
// done between the held state and the result register.
// Reset (synchronous, aresetn low) returns the state, timers, flags and registers to zero.
// A stalled result holds its value and blocks input until it is taken.
module level_control_status_fsm_core
    import lcs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration write port.
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata,
    // Input beats.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // From bit 0: tick, enable, fault_condition, ready_condition, abort_finished,
    // reset_request, reset_finished, one zero pad bit.
    input  logic [InDataWidth-1:0]  s_tdata,
    // Result beats.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // From bit 0: busy_res, done_res, error, error_code[1:0], active_cycle,
    // state_code[2:0], seven zero pad bits.
    output logic [OutDataWidth-1:0] m_tdata
);

    // Configuration registers.
    logic [TimerWidth-1:0] cycle_limit_reg;
    logic [TimerWidth-1:0] timeout_ticks_reg;
    logic                  continuous_mode_reg;

    // Scan state; the flags double as the result payload.
    logic [StateWidth-1:0]   state_reg,         state_next;
    logic [TimerWidth-1:0]   limit_timer_reg,   limit_timer_next;
    logic [TimerWidth-1:0]   timeout_timer_reg, timeout_timer_next;
    logic                    busy_reg,          busy_next;
    logic                    done_reg,          done_next;
    logic                    error_reg,         error_next;
    logic [ErrCodeWidth-1:0] err_kind_reg,      err_kind_next;
    logic                    active_reg,        active_next;
    logic                    m_tvalid_reg,      m_tvalid_next;

    lcs_in_t               in_beat;
    logic                  s_accept;
    logic [TimerWidth-1:0] limit_dec;
    logic [TimerWidth-1:0] timeout_dec;
    logic                  expired;

    assign in_beat  = lcs_in_t'(s_tdata[6:0]);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_limit_reg     <= '0;
            timeout_ticks_reg   <= '0;
            continuous_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CYCLE_LIMIT:     cycle_limit_reg     <= cfg_wdata;
                CFG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_wdata;
                CFG_CONTINUOUS_MODE: continuous_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Timers tick down while executing, before the state decision.
    always_comb begin
        limit_dec   = limit_timer_reg;
        timeout_dec = timeout_timer_reg;
        if (in_beat.tick && state_reg == ST_EXECUTING) begin
            if (cycle_limit_reg != '0) begin
                if (limit_timer_reg != '0) begin
                    limit_dec = limit_timer_reg - 1'b1;
                end else begin
                    limit_dec = cycle_limit_reg;
                end
            end
            if (timeout_timer_reg != '0) begin
                timeout_dec = timeout_timer_reg - 1'b1;
            end
        end
    end

    assign expired = (timeout_ticks_reg != '0) && (timeout_dec == '0);

    // State decision and flag update for one scan.
    always_comb begin
        state_next         = state_reg;
        limit_timer_next   = limit_dec;
        timeout_timer_next = timeout_dec;
        busy_next          = busy_reg;
        done_next          = done_reg;
        error_next         = error_reg;
        err_kind_next      = err_kind_reg;
        active_next        = active_reg;
        case (state_reg)
            ST_DORMANT: begin
                done_next     = 1'b0;
                busy_next     = 1'b0;
                error_next    = 1'b0;
                err_kind_next = ERR_NONE;
                active_next   = 1'b0;
                if (in_beat.enable) begin
                    timeout_timer_next = timeout_ticks_reg;
                    limit_timer_next   = cycle_limit_reg;
                    state_next         = ST_EXECUTING;
                end
            end
            ST_EXECUTING: begin
                busy_next   = 1'b1;
                active_next = (cycle_limit_reg == '0) || (limit_dec != '0);
                if (in_beat.fault_condition || expired) begin
                    state_next = ST_ERROR;
                end else if (!in_beat.enable) begin
                    state_next = ST_ABORTING;
                end else if (!continuous_mode_reg && in_beat.ready_condition) begin
                    state_next = ST_DONE;
                end
            end
            ST_ABORTING: begin
                active_next = 1'b0;
                if (in_beat.fault_condition || expired) begin
                    state_next = ST_ERROR;
                end else if (in_beat.abort_finished) begin
                    state_next = ST_RESETTING;
                end
            end
            ST_DONE: begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                active_next = 1'b0;
                if (!in_beat.enable) begin
                    state_next = ST_RESETTING;
                end
            end
            ST_ERROR: begin
                busy_next     = 1'b0;
                active_next   = 1'b0;
                error_next    = 1'b1;
                err_kind_next = in_beat.fault_condition ? ERR_EXTERNAL : ERR_TIMEOUT;
                if (in_beat.reset_request || !in_beat.enable) begin
                    state_next = ST_RESETTING;
                end
            end
            ST_RESETTING: begin
                done_next     = 1'b0;
                error_next    = 1'b0;
                err_kind_next = ERR_NONE;
                active_next   = 1'b0;
                if (in_beat.reset_finished) begin
                    state_next = ST_DORMANT;
                end
            end
            default: begin
                // Unused codes hold everything; timers still follow the tick rule.
            end
        endcase
    end

    // Result valid: set by an accepted beat, cleared when the result is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // State registers advance once per accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_DORMANT;
            limit_timer_reg   <= '0;
            timeout_timer_reg <= '0;
            busy_reg          <= 1'b0;
            done_reg          <= 1'b0;
            error_reg         <= 1'b0;
            err_kind_reg      <= ERR_NONE;
            active_reg        <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                state_reg         <= state_next;
                limit_timer_reg   <= limit_timer_next;
                timeout_timer_reg <= timeout_timer_next;
                busy_reg          <= busy_next;
                done_reg          <= done_next;
                error_reg         <= error_next;
                err_kind_reg      <= err_kind_next;
                active_reg        <= active_next;
            end
        end
    end

    // The held flags are the result payload; they only change on an accepted beat.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, state_reg, active_reg, err_kind_reg, error_reg,
                       done_reg, busy_reg};

    // An accepted beat always leaves a result waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
        else $error("accepted beat produced no result");

    // The error flag is only seen in error or on the way out of it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg |-> (state_reg == ST_ERROR || state_reg == ST_RESETTING))
        else $error("error flag outside error handling");

    // The done flag is only seen in done or on the way out of it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (state_reg == ST_DONE || state_reg == ST_RESETTING))
        else $error("done flag outside done handling");

    // An error code is reported exactly when the error flag is set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (err_kind_reg != ERR_NONE) == error_reg)
        else $error("error code and error flag disagree");

    // State and flags hold while no beat is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(state_reg) && $stable(busy_reg) && $stable(err_kind_reg))
        else $error("state changed without an accepted beat");

endmodule
